// ----- rtl/jsu_pkg.sv -----
// Shared types, codes and the UTF-8 encoder for the JSON string unescaper.
// Depends on nothing; decode, emit, top and bench refer to it by scoped names.
package jsu_pkg;

    // Largest number of result words that one text byte can cause
    localparam int unsigned GROUP_MAX = 6;
    localparam int unsigned IDX_W     = $clog2(GROUP_MAX);
    localparam int unsigned CNT_W     = $clog2(GROUP_MAX + 1);

    // Result word kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NO_QUOTE = 3'd0,
        ERR_CTRL     = 3'd1,
        ERR_ESC_END  = 3'd2,
        ERR_UNSUP    = 3'd3,
        ERR_BAD_U    = 3'd4,
        ERR_UNTERM   = 3'd5
    } t_err;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        t_err       code;
    } t_item;

    // All result words caused by one text byte
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        t_item [GROUP_MAX-1:0]       items;
    } t_group;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_utf8;

    localparam logic [20:0] CP_ONE_MAX   = 21'h00007F;
    localparam logic [20:0] CP_TWO_MAX   = 21'h0007FF;
    localparam logic [20:0] CP_THREE_MAX = 21'h00FFFF;
    localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_LEAD4   = 8'hF0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;

    // Encode a code point as 1 to 4 UTF-8 bytes, first byte in slot 0
    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u = '0;
        priority if (cp <= CP_ONE_MAX) begin
            u.len      = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp <= CP_TWO_MAX) begin
            u.len      = 3'd2;
            u.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
            u.bytes[1] = UTF8_CONT  | {2'b00, cp[5:0]};
        end else if (cp <= CP_THREE_MAX) begin
            u.len      = 3'd3;
            u.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            u.bytes[1] = UTF8_CONT  | {2'b00, cp[11:6]};
            u.bytes[2] = UTF8_CONT  | {2'b00, cp[5:0]};
        end else begin
            u.len      = 3'd4;
            u.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
            u.bytes[1] = UTF8_CONT  | {2'b00, cp[17:12]};
            u.bytes[2] = UTF8_CONT  | {2'b00, cp[11:6]};
            u.bytes[3] = UTF8_CONT  | {2'b00, cp[5:0]};
        end
        return u;
    endfunction

endpackage

// ----- rtl/jsu_in_if.sv -----
// Input channel of the JSON string unescaper: one text byte per word.
// No dependencies.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// ----- rtl/jsu_out_if.sv -----
// Output channel of the JSON string unescaper: one result item per word.
// No dependencies.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic [2:0] error_code;
    logic       run_last;

    modport source (output valid, output out_byte, output item_kind,
                    output error_code, output run_last, input ready);
    modport sink   (input valid, input out_byte, input item_kind,
                    input error_code, input run_last, output ready);
endinterface

// ----- rtl/jsu_decode.sv -----
// Input register, decode state and per-byte decode of the JSON string unescaper.
// Depends on jsu_pkg and jsu_in_if; hands a whole result group to jsu_emit.
module jsu_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    jsu_in_if.sink          i_in,
    input  logic            i_free,
    output logic            o_grp_valid,
    output jsu_pkg::t_group o_grp
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;

    // Top six bits of a high (D800..DBFF) and a low (DC00..DFFF) surrogate
    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;

    typedef enum logic [2:0] {
        M_IDLE, M_STR, M_ESC, M_HEX, M_PEND, M_PEND_ESC, M_PEND_HEX
    } t_mode;

    typedef enum logic [1:0] {
        OUT_NONE, OUT_RAW, OUT_CP, OUT_DONE
    } t_main;

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_fin;
    t_mode       r_mode;
    logic [1:0]  r_hc;
    logic [11:0] r_acc;
    logic [9:0]  r_ph;

    t_mode       n_mode;
    logic [1:0]  n_hc;
    logic [11:0] n_acc;
    logic [9:0]  n_ph;

    logic        move;
    logic        in_take;

    // Hex digit
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [15:0] cp16;
    logic        hex_full;
    logic        cp_is_high;
    logic        cp_is_low;

    // Outcome of a byte taken as plain string content
    logic               s_err;
    jsu_pkg::t_err      s_code;
    t_main              s_main;
    t_mode              s_mode;

    // Outcome of a byte taken as an escape letter
    logic               e_err;
    jsu_pkg::t_err      e_code;
    t_main              e_main;
    logic [7:0]         e_raw;
    t_mode              e_mode;
    logic               e_hex;

    // Combined outcome
    logic               err;
    jsu_pkg::t_err      code;
    logic               flush;
    t_main              main_kind;
    logic [7:0]         raw;
    logic [20:0]        main_cp;

    jsu_pkg::t_utf8     u_main;
    jsu_pkg::t_utf8     u_flush;
    jsu_pkg::t_item [3:0] m_items;
    jsu_pkg::t_item [2:0] f_items;
    jsu_pkg::t_item     blank;
    logic [2:0]         m_len;

    assign in_take    = i_in.valid & i_in.ready;
    assign move       = r_in_valid & i_free;
    assign i_in.ready = ~r_in_valid | i_free;

    // Classify the held byte as a hex digit
    always_comb begin
        logic dig, low, up;
        dig     = (r_byte >= CH_DIG0)  && (r_byte <= CH_DIG9);
        low     = (r_byte >= CH_LOW_A) && (r_byte <= CH_LOW_F);
        up      = (r_byte >= CH_UP_A)  && (r_byte <= CH_UP_F);
        is_hex  = dig | low | up;
        hex_val = dig ? r_byte[3:0] : r_byte[3:0] + 4'd9;
    end

    assign cp16       = {r_acc, hex_val};
    assign hex_full   = (r_hc == 2'd3);
    assign cp_is_high = (cp16[15:10] == SURR_HIGH_TAG);
    assign cp_is_low  = (cp16[15:10] == SURR_LOW_TAG);

    // String content: close, reject control bytes, open an escape or pass through
    always_comb begin
        s_err  = 1'b0;
        s_code = jsu_pkg::ERR_CTRL;
        s_main = OUT_NONE;
        s_mode = M_STR;
        priority if (r_byte == CH_QUOTE) begin
            s_main = OUT_DONE;
            s_mode = M_IDLE;
        end else if (r_byte < CH_SPACE) begin
            s_err  = 1'b1;
            s_code = jsu_pkg::ERR_CTRL;
        end else if (r_byte == CH_BSLASH) begin
            s_err  = r_fin;
            s_code = jsu_pkg::ERR_ESC_END;
            s_mode = M_ESC;
        end else begin
            s_main = OUT_RAW;
            s_err  = r_fin;
            s_code = jsu_pkg::ERR_UNTERM;
        end
    end

    // Escape letter: map to its byte, start a \u sequence or reject the letter
    always_comb begin
        e_err  = r_fin;
        e_code = jsu_pkg::ERR_UNTERM;
        e_main = OUT_RAW;
        e_raw  = r_byte;
        e_mode = M_STR;
        e_hex  = 1'b0;
        unique case (r_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: e_raw = r_byte;
            CH_B: e_raw = CH_BS;
            CH_F: e_raw = CH_FF;
            CH_N: e_raw = CH_LF;
            CH_R: e_raw = CH_CR;
            CH_T: e_raw = CH_TAB;
            CH_U: begin
                e_main = OUT_NONE;
                e_code = jsu_pkg::ERR_BAD_U;
                e_mode = M_HEX;
                e_hex  = 1'b1;
            end
            default: begin
                e_main = OUT_NONE;
                e_err  = 1'b1;
                e_code = jsu_pkg::ERR_UNSUP;
            end
        endcase
    end

    // Per-mode decode and next state
    always_comb begin
        err       = 1'b0;
        code      = jsu_pkg::ERR_NO_QUOTE;
        flush     = 1'b0;
        main_kind = OUT_NONE;
        raw       = r_byte;
        main_cp   = '0;
        n_mode    = r_mode;
        n_hc      = r_hc;
        n_acc     = r_acc;
        n_ph      = r_ph;
        unique case (r_mode)
            M_STR: begin
                err       = s_err;
                code      = s_code;
                main_kind = s_main;
                n_mode    = s_mode;
            end
            M_ESC: begin
                err       = e_err;
                code      = e_code;
                main_kind = e_main;
                raw       = e_raw;
                n_mode    = e_mode;
                if (e_hex) begin
                    n_hc  = '0;
                    n_acc = '0;
                end
            end
            M_HEX, M_PEND_HEX: begin
                if (!is_hex) begin
                    err  = 1'b1;
                    code = jsu_pkg::ERR_BAD_U;
                end else if (!hex_full) begin
                    n_acc = cp16[11:0];
                    n_hc  = r_hc + 2'd1;
                    err   = r_fin;
                    code  = jsu_pkg::ERR_BAD_U;
                end else begin
                    n_hc  = '0;
                    n_acc = '0;
                    err   = r_fin;
                    code  = jsu_pkg::ERR_UNTERM;
                    if ((r_mode == M_PEND_HEX) && cp_is_low) begin
                        main_kind = OUT_CP;
                        main_cp   = SUPP_BASE + {1'b0, r_ph, cp16[9:0]};
                        n_mode    = M_STR;
                    end else begin
                        flush = (r_mode == M_PEND_HEX);
                        if (cp_is_high) begin
                            n_ph   = cp16[9:0];
                            n_mode = M_PEND;
                        end else begin
                            main_kind = OUT_CP;
                            main_cp   = {5'b00000, cp16};
                            n_mode    = M_STR;
                        end
                    end
                end
            end
            M_PEND: begin
                if (r_byte == CH_BSLASH) begin
                    err    = r_fin;
                    code   = jsu_pkg::ERR_ESC_END;
                    n_mode = M_PEND_ESC;
                end else begin
                    flush     = 1'b1;
                    err       = s_err;
                    code      = s_code;
                    main_kind = s_main;
                    n_mode    = s_mode;
                end
            end
            M_PEND_ESC: begin
                if (r_byte == CH_U) begin
                    err    = r_fin;
                    code   = jsu_pkg::ERR_BAD_U;
                    n_mode = M_PEND_HEX;
                    n_hc   = '0;
                    n_acc  = '0;
                end else begin
                    flush     = 1'b1;
                    err       = e_err;
                    code      = e_code;
                    main_kind = e_main;
                    raw       = e_raw;
                    n_mode    = e_mode;
                    if (e_hex) begin
                        n_hc  = '0;
                        n_acc = '0;
                    end
                end
            end
            default: begin
                // Waiting for the opening quote
                if (r_byte == CH_QUOTE) begin
                    err    = r_fin;
                    code   = jsu_pkg::ERR_UNTERM;
                    n_mode = M_STR;
                end else begin
                    err  = 1'b1;
                    code = jsu_pkg::ERR_NO_QUOTE;
                end
            end
        endcase
        // Drop everything back to idle after an error or a closed string
        if (err || (n_mode == M_IDLE)) begin
            n_mode = M_IDLE;
            n_hc   = '0;
            n_acc  = '0;
            n_ph   = '0;
        end
    end

    assign u_main  = jsu_pkg::utf8_encode(main_cp);
    assign u_flush = jsu_pkg::utf8_encode({5'b00000, SURR_HIGH_TAG, r_ph});
    assign blank   = '{data: 8'h00, kind: jsu_pkg::KIND_DATA, code: jsu_pkg::ERR_NO_QUOTE};

    // Main words: raw byte, encoded code point or string end
    always_comb begin
        m_items = {4{blank}};
        m_len   = 3'd0;
        unique case (main_kind)
            OUT_RAW: begin
                m_items[0].data = raw;
                m_len           = 3'd1;
            end
            OUT_CP: begin
                for (int k = 0; k < 4; k++) begin
                    m_items[k].data = u_main.bytes[k];
                end
                m_len = u_main.len;
            end
            OUT_DONE: begin
                m_items[0].kind = jsu_pkg::KIND_DONE;
                m_len           = 3'd1;
            end
            default: m_len = 3'd0;
        endcase
        for (int k = 0; k < 3; k++) begin
            f_items[k]      = blank;
            f_items[k].data = u_flush.bytes[k];
        end
    end

    // Lay out the group: held high surrogate first, an error replaces everything
    always_comb begin
        o_grp = '0;
        if (err) begin
            o_grp.count         = jsu_pkg::CNT_W'(1);
            o_grp.items         = {jsu_pkg::GROUP_MAX{blank}};
            o_grp.items[0].kind = jsu_pkg::KIND_ERR;
            o_grp.items[0].code = code;
        end else if (flush) begin
            o_grp.count    = jsu_pkg::CNT_W'(m_len + 3'd3);
            o_grp.items[0] = f_items[0];
            o_grp.items[1] = f_items[1];
            o_grp.items[2] = f_items[2];
            o_grp.items[3] = m_items[0];
            o_grp.items[4] = m_items[1];
            o_grp.items[5] = m_items[2];
        end else begin
            o_grp.count    = jsu_pkg::CNT_W'(m_len);
            o_grp.items[0] = m_items[0];
            o_grp.items[1] = m_items[1];
            o_grp.items[2] = m_items[2];
            o_grp.items[3] = m_items[3];
            o_grp.items[4] = blank;
            o_grp.items[5] = blank;
        end
    end

    assign o_grp_valid = r_in_valid;

    // Hold the input word and advance the decode state on each hand-over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_hc       <= '0;
            r_acc      <= '0;
            r_ph       <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_mode <= n_mode;
                r_hc   <= n_hc;
                r_acc  <= n_acc;
                r_ph   <= n_ph;
            end
        end
        if (in_take) begin
            r_byte <= i_in.text_byte;
            r_fin  <= i_in.final_byte;
        end
    end

endmodule

// ----- rtl/jsu_emit.sv -----
// Result register of the JSON string unescaper: holds one group, sends it word by word.
// Depends on jsu_pkg and jsu_out_if.
module jsu_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_grp_valid,
    input  jsu_pkg::t_group i_grp,
    output logic            o_free,
    jsu_out_if.source       o_out
);

    jsu_pkg::t_item [jsu_pkg::GROUP_MAX-1:0] r_items;
    logic [jsu_pkg::CNT_W-1:0]               r_cnt;
    logic [jsu_pkg::IDX_W-1:0]               r_idx;

    logic           take;
    logic           last;
    logic           load;
    jsu_pkg::t_item cur;

    assign cur  = r_items[r_idx];
    assign take = o_out.valid & o_out.ready;
    assign last = (jsu_pkg::CNT_W'(r_idx) + jsu_pkg::CNT_W'(1)) == r_cnt;

    // Free when empty or when the last word of the group leaves now
    assign o_free = (r_cnt == '0) | (take & last);
    assign load   = i_grp_valid & o_free;

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.out_byte   = cur.data;
    assign o_out.item_kind  = cur.kind;
    assign o_out.error_code = cur.code;
    assign o_out.run_last   = last;

    // Load a new group or step to the next word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (load) begin
                r_cnt <= i_grp.count;
                r_idx <= '0;
            end else if (take && last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else if (take) begin
                r_idx <= r_idx + jsu_pkg::IDX_W'(1);
            end
        end
        if (load) begin
            r_items <= i_grp.items;
        end
    end

endmodule

// ----- rtl/json_string_unescape_utf8_top.sv -----
// JSON string unescaper with UTF-8 output: top level.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_decode and jsu_emit.
//
// Feed JSON text one byte per word, with final_byte set on the last byte of the
// buffer. Each string must open with a double quote; plain bytes pass through,
// the escapes \" \\ \/ \b \f \n \r \t give their byte, and \uXXXX is sent as
// UTF-8, with a high surrogate merged with a directly following \u low
// surrogate. Each byte gives zero to six result words, the last of them flagged
// by run_last. A result word of kind error means the consumer must drop the
// string it was building; the block then waits for a new opening quote.
// A byte is taken every cycle while each byte gives at most one result word
// and the receiver is ready; a byte that gives more holds the input side
// until its last word leaves the result register, which sends one word per
// cycle while the receiver is ready. Bytes pass the input and result registers.
module json_string_unescape_utf8_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic            grp_valid;
    logic            grp_free;
    jsu_pkg::t_group grp;

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_free      (grp_free),
        .o_grp_valid (grp_valid),
        .o_grp       (grp)
    );

    jsu_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (grp),
        .o_free      (grp_free),
        .o_out       (o_out)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for json_string_unescape_utf8_top: feeds JSON text words,
// predicts the UTF-8 / done / error words in a scoreboard and checks each one.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the top level of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HALF_PERIOD  = 1;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned RANDOM_ITEMS = 280;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned END_CYCLES   = 12;
    // Receiver hold-off and the stretch with no idling, placed by input count
    localparam int unsigned HOLD_AT      = 150;
    localparam int unsigned HOLD_LEN     = 300;
    localparam int unsigned CALM_FROM    = 60;
    localparam int unsigned CALM_TO      = 110;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    // Error field reads zero on data and done words
    localparam jsu_pkg::t_err NO_ERR = jsu_pkg::ERR_NO_QUOTE;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_STR,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_PEND,
        SCAN_PEND_ESC,
        SCAN_PEND_HEX
    } t_scan;

    typedef struct packed {
        jsu_pkg::t_item word;
        logic           last;
    } t_decoded;

    typedef struct packed {
        logic [7:0] text;
        logic       fin;
        logic       drain;
    } t_text_word;

    logic clk = 1'b0;
    logic rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape_utf8_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state
    t_scan          scan_mode;
    logic [2:0]     nib_cnt;
    logic [15:0]    u_acc;
    logic [9:0]     held_hi;
    jsu_pkg::t_item step_words[$];

    t_decoded    decoded_q[$];
    t_text_word  text_q[$];

    int unsigned in_taken = 0;
    int unsigned fail_cnt = 0;
    int unsigned feed_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    bit          held_off = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_scan();
        scan_mode = SCAN_IDLE;
        nib_cnt   = '0;
        u_acc     = '0;
        held_hi   = '0;
    endfunction

    function automatic void add_word(input logic [7:0] data, input jsu_pkg::t_kind kind,
                                     input jsu_pkg::t_err code);
        jsu_pkg::t_item w;
        w.data = data;
        w.kind = kind;
        w.code = code;
        step_words.push_back(w);
    endfunction

    // An error replaces whatever this byte produced and drops back to idle
    function automatic void raise_err(input jsu_pkg::t_err code);
        step_words.delete();
        add_word(8'h00, jsu_pkg::KIND_ERR, code);
        clear_scan();
    endfunction

    function automatic void put_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_word(cp[7:0], jsu_pkg::KIND_DATA, NO_ERR);
        end else if (cp < 21'h800) begin
            add_word({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, NO_ERR);
            add_word({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, NO_ERR);
        end else if (cp < 21'h10000) begin
            add_word({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, NO_ERR);
            add_word({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, NO_ERR);
            add_word({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, NO_ERR);
        end else begin
            add_word({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, NO_ERR);
            add_word({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, NO_ERR);
            add_word({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, NO_ERR);
            add_word({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, NO_ERR);
        end
    endfunction

    // Send a held high surrogate on its own
    function automatic void flush_held();
        put_code_point({5'b0, 6'b110110, held_hi});
        held_hi = '0;
    endfunction

    function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
        v = '0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 10);
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void string_byte(input logic [7:0] c, input logic fin);
        scan_mode = SCAN_STR;
        if (c == CH_QUOTE) begin
            add_word(8'h00, jsu_pkg::KIND_DONE, NO_ERR);
            clear_scan();
        end else if (c < CTRL_LIMIT) begin
            raise_err(jsu_pkg::ERR_CTRL);
        end else if (c == CH_BSLASH) begin
            if (fin) raise_err(jsu_pkg::ERR_ESC_END);
            else scan_mode = SCAN_ESC;
        end else begin
            add_word(c, jsu_pkg::KIND_DATA, NO_ERR);
            if (fin) raise_err(jsu_pkg::ERR_UNTERM);
        end
    endfunction

    function automatic void escape_byte(input logic [7:0] c, input logic fin);
        logic [7:0] b;
        bit         known;
        known = 1'b1;
        b     = c;
        if (c == CH_U) begin
            if (fin) begin
                raise_err(jsu_pkg::ERR_BAD_U);
            end else begin
                scan_mode = SCAN_HEX;
                nib_cnt   = '0;
                u_acc     = '0;
            end
            return;
        end
        case (c)
            "\"", "\\", "/": b = c;
            "b": b = 8'h08;
            "f": b = 8'h0C;
            "n": b = 8'h0A;
            "r": b = 8'h0D;
            "t": b = 8'h09;
            default: known = 1'b0;
        endcase
        if (!known) begin
            raise_err(jsu_pkg::ERR_UNSUP);
            return;
        end
        add_word(b, jsu_pkg::KIND_DATA, NO_ERR);
        scan_mode = SCAN_STR;
        if (fin) raise_err(jsu_pkg::ERR_UNTERM);
    endfunction

    function automatic void hex_byte(input logic [7:0] c, input logic fin, input bit held);
        logic [3:0]  v;
        logic [15:0] cp;
        if (!hex_val(c, v)) begin
            raise_err(jsu_pkg::ERR_BAD_U);
            return;
        end
        u_acc   = {u_acc[11:0], v};
        nib_cnt = nib_cnt + 3'd1;
        if (nib_cnt < 3'd4) begin
            if (fin) raise_err(jsu_pkg::ERR_BAD_U);
            return;
        end
        cp      = u_acc;
        nib_cnt = '0;
        u_acc   = '0;
        if (held && cp >= 16'hDC00 && cp <= 16'hDFFF) begin
            // merge the pair into one supplementary code point
            put_code_point(21'h10000 + {1'b0, held_hi, cp[9:0]});
            held_hi   = '0;
            scan_mode = SCAN_STR;
        end else begin
            if (held) flush_held();
            if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                held_hi   = cp[9:0];
                scan_mode = SCAN_PEND;
            end else begin
                put_code_point({5'b0, cp});
                scan_mode = SCAN_STR;
            end
        end
        if (fin) raise_err(jsu_pkg::ERR_UNTERM);
    endfunction

    // Work out every word one text byte causes and queue them as expected
    function automatic void unescape_byte(input logic [7:0] c, input logic fin);
        t_decoded d;
        step_words.delete();
        case (scan_mode)
            SCAN_STR: string_byte(c, fin);
            SCAN_ESC: escape_byte(c, fin);
            SCAN_HEX: hex_byte(c, fin, 1'b0);
            SCAN_PEND: begin
                if (c == CH_BSLASH) begin
                    if (fin) raise_err(jsu_pkg::ERR_ESC_END);
                    else scan_mode = SCAN_PEND_ESC;
                end else begin
                    flush_held();
                    string_byte(c, fin);
                end
            end
            SCAN_PEND_ESC: begin
                if (c == CH_U) begin
                    if (fin) begin
                        raise_err(jsu_pkg::ERR_BAD_U);
                    end else begin
                        scan_mode = SCAN_PEND_HEX;
                        nib_cnt   = '0;
                        u_acc     = '0;
                    end
                end else begin
                    flush_held();
                    escape_byte(c, fin);
                end
            end
            SCAN_PEND_HEX: hex_byte(c, fin, 1'b1);
            default: begin
                clear_scan();
                if (c == CH_QUOTE) begin
                    if (fin) raise_err(jsu_pkg::ERR_UNTERM);
                    else scan_mode = SCAN_STR;
                end else begin
                    raise_err(jsu_pkg::ERR_NO_QUOTE);
                end
            end
        endcase
        foreach (step_words[k]) begin
            d.word = step_words[k];
            d.last = (k == step_words.size() - 1);
            decoded_q.push_back(d);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    // Mostly back to back, some short gaps, a few long ones
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (in_taken >= CALM_FROM && in_taken < CALM_TO) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic fin,
                                       input logic drain);
        t_text_word w;
        w.text  = b;
        w.fin   = fin;
        w.drain = drain;
        text_q.push_back(w);
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0, 1'b0);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic void queue_hex4(input logic [15:0] v);
        queue_text("\\u");
        for (int i = 3; i >= 0; i--) queue_byte(hex_char(v[i*4 +: 4]), 1'b0, 1'b0);
    endfunction

    function automatic logic [15:0] pick_code(input int unsigned sel);
        case (sel)
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                           : 16'($urandom_range(16'hE000, 16'hFFFF));
            3: return 16'($urandom_range(16'hD800, 16'hDBFF));
            default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(0, 7))
            0: return "\"";
            1: return "\\";
            2: return "/";
            3: return "b";
            4: return "f";
            5: return "n";
            6: return "r";
            default: return "t";
        endcase
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        case (c)
            "\"", "\\", "/", "b", "f", "n", "r", "t", "u": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] not_hex_char();
        logic [7:0] c;
        logic [3:0] v;
        do c = 8'($urandom_range(0, 255)); while (hex_val(c, v));
        return c;
    endfunction

    // One well-formed string with random content, now and then broken
    function automatic void queue_string(input logic drain_first);
        int unsigned pieces;
        int unsigned r;
        int unsigned digits;
        logic [7:0]  c;
        queue_byte(CH_QUOTE, 1'b0, drain_first);
        pieces = $urandom_range(0, 6);
        repeat (pieces) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                queue_byte(plain_char(), 1'b0, 1'b0);
            end else if (r < 50) begin
                queue_byte(CH_BSLASH, 1'b0, 1'b0);
                queue_byte(escape_letter(), 1'b0, 1'b0);
            end else if (r < 65) begin
                queue_hex4(pick_code($urandom_range(0, 2)));
            end else if (r < 75) begin
                queue_hex4(pick_code(3));
                queue_hex4(pick_code(4));
            end else if (r < 85) begin
                // lone high surrogate: the next piece decides what happens
                queue_hex4(pick_code(3));
            end else if (r < 90) begin
                queue_hex4(pick_code(4));
            end else begin
                // a broken piece ends the string
                case ($urandom_range(0, 2))
                    0: queue_byte(8'($urandom_range(0, 31)), 1'b0, 1'b0);
                    1: begin
                        do c = 8'($urandom_range(8'h21, 8'h7E)); while (is_escape_letter(c));
                        queue_byte(CH_BSLASH, 1'b0, 1'b0);
                        queue_byte(c, 1'b0, 1'b0);
                    end
                    default: begin
                        queue_text("\\u");
                        repeat ($urandom_range(0, 3))
                            queue_byte(hex_char(4'($urandom_range(0, 15))), 1'b0, 1'b0);
                        queue_byte(not_hex_char(), 1'b0, 1'b0);
                    end
                endcase
                return;
            end
        end
        r = $urandom_range(0, 99);
        if (r < 80) begin
            queue_byte(CH_QUOTE, $urandom_range(0, 9) == 0, 1'b0);
        end else if (r < 86) begin
            queue_byte(plain_char(), 1'b1, 1'b0);
        end else if (r < 90) begin
            queue_byte(CH_BSLASH, 1'b1, 1'b0);
        end else if (r < 95) begin
            // input ends inside a \u escape
            digits = $urandom_range(0, 3);
            queue_byte(CH_BSLASH, 1'b0, 1'b0);
            queue_byte(CH_U, digits == 0, 1'b0);
            for (int i = 1; i <= digits; i++)
                queue_byte(hex_char(4'($urandom_range(0, 15))), i == digits, 1'b0);
        end else begin
            queue_byte(CH_BSLASH, 1'b0, 1'b0);
            queue_byte(escape_letter(), 1'b1, 1'b0);
        end
    endfunction

    function automatic void queue_noise();
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)),
                                                 $urandom_range(0, 4) == 0, 1'b0);
    endfunction

    // ---------------------------------------------------------------- driver

    // Predict each accepted word, then offer the next one after its gap
    always @(posedge clk) begin : feed
        t_text_word nxt;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                unescape_byte(in_if.text_byte, in_if.final_byte);
                in_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    in_if.valid <= 1'b0;
                end else if (text_q.size() > 0 &&
                             !(text_q[0].drain && decoded_q.size() != 0)) begin
                    nxt = text_q.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.text_byte  <= nxt.text;
                    in_if.final_byte <= nxt.fin;
                    feed_gap = idle_span();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Check each accepted result word against the oldest expectation
    always @(posedge clk) begin : observe
        t_decoded want;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected word: out_byte %02h item_kind %0d error_code %0d run_last %0b",
                           out_if.out_byte, out_if.item_kind, out_if.error_code,
                           out_if.run_last);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (out_if.out_byte !== want.word.data) begin
                        $error("out_byte: expected %02h, got %02h", want.word.data,
                               out_if.out_byte);
                        fail_cnt++;
                    end
                    if (out_if.item_kind !== want.word.kind) begin
                        $error("item_kind: expected %0d, got %0d", want.word.kind,
                               out_if.item_kind);
                        fail_cnt++;
                    end
                    if (out_if.error_code !== want.word.code) begin
                        $error("error_code: expected %0d, got %0d", want.word.code,
                               out_if.error_code);
                        fail_cnt++;
                    end
                    if (out_if.run_last !== want.last) begin
                        $error("run_last: expected %0b, got %0b", want.last,
                               out_if.run_last);
                        fail_cnt++;
                    end
                end
                sink_gap = idle_span();
            end
            // hold off once for a long stretch so the block backs up
            if (!held_off && in_taken >= HOLD_AT) begin
                held_off  = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Abort when neither side has moved a word for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("FAIL json_string_unescape_utf8_top");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : run
        int unsigned dir_n;
        int unsigned total;
        int unsigned strings;
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.text_byte   = 8'h00;
        in_if.final_byte  = 1'b0;
        out_if.ready      = 1'b0;
        clear_scan();

        // directed: byte extremes, every error, the largest surrogate pair
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(CH_QUOTE, 1'b1, 1'b0);
        queue_byte(CH_QUOTE, 1'b0, 1'b0);
        queue_byte(8'h20, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h1F, 1'b0, 1'b0);
        queue_text("\"\\q");
        queue_byte(CH_QUOTE, 1'b0, 1'b0);
        queue_byte(CH_BSLASH, 1'b1, 1'b0);
        queue_text("\"\\uDBFF\\udfff\\uZ");
        dir_n = text_q.size();

        // random: mostly well-formed strings, some noise, a drain now and then
        strings = 0;
        while (text_q.size() < dir_n + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 12) begin
                queue_noise();
            end else begin
                strings++;
                queue_string(strings % 4 == 1);
            end
        end
        total = text_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (in_taken < total) @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        if (fail_cnt == 0) begin
            $display("PASS json_string_unescape_utf8_top");
        end else begin
            $display("FAIL json_string_unescape_utf8_top");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_decode.sv
rtl/jsu_emit.sv
rtl/json_string_unescape_utf8_top.sv
tb/testbench.sv
